/* rtl/core/pmt_pkg.sv */
package pmt_pkg;

  localparam int unsigned ProcSlots  = 16;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned SlotW      = $clog2(ProcSlots);
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned QAddrW     = SlotW + PtrW;
  localparam int unsigned QWordW     = 40;
  localparam int unsigned FifoDepth  = 2;

  localparam logic [15:0] PidLimit = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_SPAWN = 3'd0,
    CMD_SEND  = 3'd1,
    CMD_RECV  = 3'd2,
    CMD_QUERY = 3'd3,
    CMD_SETC  = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NONE  = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  caller_task;
    logic [7:0]  new_task;
    logic [15:0] target_pid;
    logic [31:0] cap_mask;
    logic [31:0] payload;
  } item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] pid_out;
    logic [15:0] parent_out;
    logic [7:0]  sender_task;
    logic [31:0] payload_out;
    logic [3:0]  backlog;
    logic [31:0] caps_out;
  } result_t;

endpackage

/* rtl/core/pmt_ram.sv */
module pmt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* rtl/core/pmt_fifo.sv */
module pmt_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pmt_pkg::item_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pmt_pkg::item_t out_data_o
);
  import pmt_pkg::*;

  item_t      buf_q [FifoDepth];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'(FifoDepth));
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rp_q];
  assign push = in_valid_i & in_ready_o;
  assign pop  = out_valid_o & out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= in_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'(FifoDepth)) else $error("fifo count overflow");
  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'(FifoDepth)) |-> !push) else $error("push into full fifo");
  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> !pop) else $error("pop from empty fifo");
`endif
endmodule

/* rtl/core/pmt_exec.sv */
module pmt_exec (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pmt_pkg::item_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pmt_pkg::result_t out_data_o
);
  import pmt_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_MEM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]  state_q, state_d;
  item_t       it_q;
  result_t     res_q, res_d;
  logic        out_v_q;

  logic [ProcSlots-1:0] act_q;
  logic [15:0] pid_q  [ProcSlots];
  logic [15:0] par_q  [ProcSlots];
  logic [7:0]  task_q [ProcSlots];
  logic [31:0] caps_q [ProcSlots];
  logic [PtrW-1:0] head_q [ProcSlots];
  logic [PtrW-1:0] tail_q [ProcSlots];
  logic [15:0] pidc_q;

  // search results, registered
  logic [SlotW-1:0] hit_q;
  logic             hit_ok_q, known_q;
  logic [15:0]      parent_q;

  logic [ProcSlots-1:0] m_pid, m_task, m_rx, m_free;
  logic [SlotW-1:0] s_idx, f_idx, t_idx, r_idx;
  logic             s_ok, f_ok, t_ok, r_ok;

  always_comb begin
    for (int i = 0; i < ProcSlots; i++) begin
      m_pid[i]  = act_q[i] && (pid_q[i] == it_q.target_pid);
      m_task[i] = act_q[i] && (task_q[i] == it_q.caller_task);
      m_rx[i]   = m_task[i] && (head_q[i] != tail_q[i]);
      m_free[i] = !act_q[i];
    end
    s_idx = '0; s_ok = 1'b0;
    f_idx = '0; f_ok = 1'b0;
    t_idx = '0; t_ok = 1'b0;
    r_idx = '0; r_ok = 1'b0;
    for (int i = ProcSlots - 1; i >= 0; i--) begin
      if (m_pid[i])  begin s_idx = SlotW'(i); s_ok = 1'b1; end
      if (m_free[i]) begin f_idx = SlotW'(i); f_ok = 1'b1; end
      if (m_task[i]) begin t_idx = SlotW'(i); t_ok = 1'b1; end
      if (m_rx[i])   begin r_idx = SlotW'(i); r_ok = 1'b1; end
    end
  end

  logic [QWordW-1:0] q_rdata;
  logic              q_we;
  logic [QAddrW-1:0] q_waddr, q_raddr;

  assign q_we    = (state_q == S_MEM) && (it_q.cmd == CMD_SEND) && hit_ok_q &&
                   ((head_q[hit_q] + PtrW'(1)) != tail_q[hit_q]);
  assign q_waddr = {hit_q, head_q[hit_q]};
  assign q_raddr = {r_idx, tail_q[r_idx]};

  pmt_ram #(.Width(QWordW), .Depth(ProcSlots * QueueDepth)) u_queue (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i ({it_q.caller_task, it_q.payload}),
    .raddr_i (q_raddr),
    .rdata_o (q_rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE) && !out_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = res_q;

  logic [PtrW-1:0] nx, diff;
  always_comb begin
    nx   = head_q[hit_q] + PtrW'(1);
    diff = head_q[hit_q] - tail_q[hit_q];
    res_d = '0;
    res_d.status = ST_NONE;
    unique case (it_q.cmd)
      CMD_SPAWN: if (hit_ok_q && pidc_q < PidLimit) begin
        res_d.status = ST_OK; res_d.pid_out = pidc_q; res_d.parent_out = parent_q;
      end
      CMD_SEND: if (hit_ok_q) res_d.status = (nx == tail_q[hit_q]) ? ST_FULL : ST_OK;
      CMD_RECV: if (hit_ok_q) begin
        res_d.status = ST_OK;
        res_d.sender_task = q_rdata[39:32];
        res_d.payload_out = q_rdata[31:0];
      end else if (known_q) res_d.status = ST_EMPTY;
      CMD_QUERY: if (hit_ok_q) begin
        res_d.status = ST_OK;
        res_d.backlog = (PtrW > 4 && diff > PtrW'(15)) ? 4'hF : 4'(diff);
        res_d.caps_out = caps_q[hit_q];
        res_d.parent_out = par_q[hit_q];
      end
      CMD_SETC: if (hit_ok_q) res_d.status = ST_OK;
      default: res_d.status = ST_NONE;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i && in_ready_o) state_d = S_SRCH;
      S_SRCH: state_d = S_MEM;
      S_MEM:  state_d = S_OUT;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // payload registers; the result is taken before the table update lands
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) it_q <= in_data_i;
    if (state_q == S_SRCH) begin
      parent_q <= t_ok ? pid_q[t_idx] : 16'd0;
      known_q  <= t_ok;
      unique case (it_q.cmd)
        CMD_SPAWN: begin hit_q <= f_idx; hit_ok_q <= f_ok; end
        CMD_RECV:  begin hit_q <= r_idx; hit_ok_q <= r_ok; end
        default:   begin hit_q <= s_idx; hit_ok_q <= s_ok; end
      endcase
    end
    if (state_q == S_MEM) res_q <= res_d;
    if (state_q == S_MEM && hit_ok_q) begin
      if (it_q.cmd == CMD_SPAWN && pidc_q < PidLimit) begin
        pid_q[hit_q]  <= pidc_q;
        par_q[hit_q]  <= parent_q;
        task_q[hit_q] <= it_q.new_task;
        caps_q[hit_q] <= it_q.cap_mask;
      end
      if (it_q.cmd == CMD_SETC) caps_q[hit_q] <= it_q.cap_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_v_q <= 1'b0;
      act_q   <= '0;
      pidc_q  <= 16'd1;
      for (int i = 0; i < ProcSlots; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_OUT) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (state_q == S_MEM && hit_ok_q) begin
        unique case (it_q.cmd)
          CMD_SPAWN: if (pidc_q < PidLimit) begin
            act_q[hit_q]  <= 1'b1;
            head_q[hit_q] <= '0;
            tail_q[hit_q] <= '0;
            pidc_q <= pidc_q + 16'd1;
          end
          CMD_SEND: if (q_we) head_q[hit_q] <= head_q[hit_q] + PtrW'(1);
          CMD_RECV: tail_q[hit_q] <= tail_q[hit_q] + PtrW'(1);
          default: ;
        endcase
      end
    end
  end

`ifndef SYNTHESIS
  a_pid_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pidc_q != 16'd0) else $error("pid counter wrapped");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_ready_i) |=> $stable(res_q)) else $error("result changed");
  a_we_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_we |-> (state_q == S_MEM)) else $error("queue write outside mem phase");
`endif
endmodule

/* rtl/core/process_mailbox_table.sv */
// Process table with per-process ring mailboxes.
// Each command passes the input queue, the table search, the mailbox memory and the result
// register in that order. The sequencer handles one command at a time and takes the next
// one only when idle, since it waits for its result register to empty.
// The input queue (2 entries) keeps taking transfers while a command executes.
// Reset (rst_ni low, async): no slots active, mailboxes empty, pid counter 1.
module process_mailbox_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // cmd[2:0] caller_task[10:3] new_task[18:11] target_pid[34:19]
  // cap_mask[66:35] payload[98:67], zero pad to 104
  input  logic [103:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // status[1:0] pid_out[17:2] parent_out[33:18] sender_task[41:34]
  // payload_out[73:42] backlog[77:74] caps_out[109:78], zero pad to 112
  output logic [111:0] m_axis_tdata_o
);
  import pmt_pkg::*;

  item_t   in_item, q_item;
  result_t res;
  logic    q_valid, q_ready;

  // unpack the input transfer
  assign in_item.cmd         = s_axis_tdata_i[2:0];
  assign in_item.caller_task = s_axis_tdata_i[10:3];
  assign in_item.new_task    = s_axis_tdata_i[18:11];
  assign in_item.target_pid  = s_axis_tdata_i[34:19];
  assign in_item.cap_mask    = s_axis_tdata_i[66:35];
  assign in_item.payload     = s_axis_tdata_i[98:67];

  // front: command queue
  pmt_fifo u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_data_i   (in_item),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_data_o  (q_item)
  );

  // back: table search, mailbox memory, result register
  pmt_exec u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_valid),
    .in_ready_o  (q_ready),
    .in_data_i   (q_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_data_o  (res)
  );

  assign m_axis_tdata_o = {2'b00, res.caps_out, res.backlog, res.payload_out,
                           res.sender_task, res.parent_out, res.pid_out, res.status};
endmodule
